// File: sv/cal_edit_pkg.sv
`default_nettype none

package cal_edit_pkg;

   // event codes carried in req_mode
   localparam logic [2:0] MODE_TICK = 3'd0;
   localparam logic [2:0] MODE_NEXT = 3'd1;
   localparam logic [2:0] MODE_INC  = 3'd2;
   localparam logic [2:0] MODE_DEC  = 3'd3;
   localparam logic [2:0] MODE_LOAD = 3'd4;

   // field indexes for selection and loads
   localparam logic [2:0] FLD_YEAR   = 3'd0;
   localparam logic [2:0] FLD_MONTH  = 3'd1;
   localparam logic [2:0] FLD_DAY    = 3'd2;
   localparam logic [2:0] FLD_HOUR   = 3'd3;
   localparam logic [2:0] FLD_MINUTE = 3'd4;
   localparam logic [2:0] FLD_SECOND = 3'd5;

   localparam logic [6:0] YEAR_MAX   = 7'd99;
   localparam logic [3:0] MONTH_MAX  = 4'd12;
   localparam logic [4:0] HOUR_MAX   = 5'd23;
   localparam logic [5:0] MINSEC_MAX = 6'd59;

   // register file
   localparam int        CSR_ADDR_W       = 3;
   localparam logic      CSR_BLINK_PERIOD = 1'b0;
   localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;

   typedef struct packed {
      logic [6:0]  year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  sel;
      logic [15:0] tick;
      logic        blink;
   } cal_state_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] load_index;
      logic [6:0] load_value;
   } cal_req_type;

   localparam cal_state_type STATE_RST = '{
      year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0,
      second: 6'd0, sel: 3'd0, tick: 16'd0, blink: 1'b0};

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
      logic [4:0] len;
      case (month) inside
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2:                    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// File: sv/cal_edit_csr.sv
`default_nettype none

module cal_edit_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [cal_edit_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic      [31:0]                        csr_prdata,
   output logic                                    csr_pready,
   output logic      [15:0]                        blink_period
);

   logic [15:0] blink_period_ff;
   logic        wr_en;
   logic        reg_idx;

   assign reg_idx = csr_paddr[2];
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_period_ff <= cal_edit_pkg::BLINK_PERIOD_RST;
      end else if (wr_en && reg_idx == cal_edit_pkg::CSR_BLINK_PERIOD) begin
         blink_period_ff <= csr_pwdata[15:0];
      end
   end

   always_comb begin
      unique case (reg_idx)
         cal_edit_pkg::CSR_BLINK_PERIOD: csr_prdata = {16'd0, blink_period_ff};
         default:                        csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready   = 1'b1;
   assign blink_period = blink_period_ff;

endmodule

`default_nettype wire

// File: sv/cal_edit_update.sv
`default_nettype none

module cal_edit_update (
   input  wire cal_edit_pkg::cal_state_type cur,
   input  wire cal_edit_pkg::cal_req_type   req,
   input  wire logic [15:0]                 blink_period,
   output cal_edit_pkg::cal_state_type      nxt
);

   logic       inc;
   logic       dec;
   logic       ld;
   logic       sel_year, sel_month, sel_day, sel_hour, sel_minute, sel_second;
   logic       ld_year, ld_month, ld_day, ld_hour, ld_minute, ld_second;
   logic [6:0] year_n;
   logic [3:0] month_n;
   logic [4:0] day_n;
   logic [4:0] day_len;
   logic [4:0] hour_n;
   logic [5:0] minute_n;
   logic [5:0] second_n;
   logic [15:0] tick_sum;
   logic [6:0] lv;

   assign inc = (req.mode == cal_edit_pkg::MODE_INC);
   assign dec = (req.mode == cal_edit_pkg::MODE_DEC);
   assign ld  = (req.mode == cal_edit_pkg::MODE_LOAD);
   assign lv  = req.load_value;

   assign sel_year   = (cur.sel == cal_edit_pkg::FLD_YEAR);
   assign sel_month  = (cur.sel == cal_edit_pkg::FLD_MONTH);
   assign sel_day    = (cur.sel == cal_edit_pkg::FLD_DAY);
   assign sel_hour   = (cur.sel == cal_edit_pkg::FLD_HOUR);
   assign sel_minute = (cur.sel == cal_edit_pkg::FLD_MINUTE);
   // out-of-range selections edit the second field
   assign sel_second = !(sel_year | sel_month | sel_day | sel_hour | sel_minute);

   assign ld_year   = ld && (req.load_index == cal_edit_pkg::FLD_YEAR);
   assign ld_month  = ld && (req.load_index == cal_edit_pkg::FLD_MONTH);
   assign ld_day    = ld && (req.load_index == cal_edit_pkg::FLD_DAY);
   assign ld_hour   = ld && (req.load_index == cal_edit_pkg::FLD_HOUR);
   assign ld_minute = ld && (req.load_index == cal_edit_pkg::FLD_MINUTE);
   assign ld_second = ld && (req.load_index == cal_edit_pkg::FLD_SECOND);

   always_comb begin
      year_n = cur.year;
      if (inc && sel_year) begin
         year_n = (cur.year >= cal_edit_pkg::YEAR_MAX) ? 7'd0 : cur.year + 7'd1;
      end else if (dec && sel_year) begin
         year_n = (cur.year == 7'd0) ? 7'd0 : cur.year - 7'd1;
      end else if (ld_year) begin
         year_n = (lv > cal_edit_pkg::YEAR_MAX) ? cal_edit_pkg::YEAR_MAX : lv;
      end
   end

   always_comb begin
      month_n = cur.month;
      if (inc && sel_month) begin
         month_n = (cur.month >= cal_edit_pkg::MONTH_MAX) ? 4'd1 : cur.month + 4'd1;
      end else if (dec && sel_month) begin
         month_n = (cur.month <= 4'd1) ? cal_edit_pkg::MONTH_MAX : cur.month - 4'd1;
      end else if (ld_month) begin
         if (lv < 7'd1) begin
            month_n = 4'd1;
         end else if (lv > {3'd0, cal_edit_pkg::MONTH_MAX}) begin
            month_n = cal_edit_pkg::MONTH_MAX;
         end else begin
            month_n = lv[3:0];
         end
      end
   end

   // length follows the updated month and year so a day past it is caught below
   assign day_len = cal_edit_pkg::month_len(month_n, year_n);

   always_comb begin
      day_n = cur.day;
      if (inc && sel_day) begin
         day_n = cur.day + 5'd1;
      end else if (dec && sel_day) begin
         day_n = (cur.day <= 5'd1) ? day_len : cur.day - 5'd1;
      end else if (ld_day) begin
         if (lv < 7'd1) begin
            day_n = 5'd1;
         end else if (lv > {2'd0, day_len}) begin
            day_n = day_len;
         end else begin
            day_n = lv[4:0];
         end
      end
      // drop to the first when beyond the month after any edit
      if ((inc || dec || ld) && (day_n > day_len || day_n == 5'd0)) begin
         day_n = 5'd1;
      end
   end

   always_comb begin
      hour_n = cur.hour;
      if (inc && sel_hour) begin
         hour_n = (cur.hour >= cal_edit_pkg::HOUR_MAX) ? 5'd0 : cur.hour + 5'd1;
      end else if (dec && sel_hour) begin
         hour_n = (cur.hour == 5'd0) ? cal_edit_pkg::HOUR_MAX : cur.hour - 5'd1;
      end else if (ld_hour) begin
         hour_n = (lv > {2'd0, cal_edit_pkg::HOUR_MAX}) ? cal_edit_pkg::HOUR_MAX : lv[4:0];
      end
   end

   always_comb begin
      minute_n = cur.minute;
      if (inc && sel_minute) begin
         minute_n = (cur.minute >= cal_edit_pkg::MINSEC_MAX) ? 6'd0 : cur.minute + 6'd1;
      end else if (dec && sel_minute) begin
         minute_n = (cur.minute == 6'd0) ? cal_edit_pkg::MINSEC_MAX : cur.minute - 6'd1;
      end else if (ld_minute) begin
         minute_n = (lv > {1'b0, cal_edit_pkg::MINSEC_MAX}) ?
                    cal_edit_pkg::MINSEC_MAX : lv[5:0];
      end
   end

   always_comb begin
      second_n = cur.second;
      if (inc && sel_second) begin
         second_n = (cur.second >= cal_edit_pkg::MINSEC_MAX) ? 6'd0 : cur.second + 6'd1;
      end else if (dec && sel_second) begin
         second_n = (cur.second == 6'd0) ? cal_edit_pkg::MINSEC_MAX : cur.second - 6'd1;
      end else if (ld_second) begin
         second_n = (lv > {1'b0, cal_edit_pkg::MINSEC_MAX}) ?
                    cal_edit_pkg::MINSEC_MAX : lv[5:0];
      end
   end

   assign tick_sum = cur.tick + 16'd1;

   always_comb begin
      nxt        = cur;
      nxt.year   = year_n;
      nxt.month  = month_n;
      nxt.day    = day_n;
      nxt.hour   = hour_n;
      nxt.minute = minute_n;
      nxt.second = second_n;
      if (req.mode == cal_edit_pkg::MODE_TICK) begin
         if (tick_sum >= blink_period) begin
            nxt.tick  = 16'd0;
            nxt.blink = ~cur.blink;
         end else begin
            nxt.tick = tick_sum;
         end
      end else if (req.mode == cal_edit_pkg::MODE_NEXT) begin
         nxt.sel = (cur.sel >= cal_edit_pkg::FLD_SECOND) ? cal_edit_pkg::FLD_YEAR :
                   cur.sel + 3'd1;
      end
   end

endmodule

`default_nettype wire

// File: sv/calendar_time_set_editor_top.sv
// Channel   Direction  Ports
// -------   ---------  ---------------------------------------------------------
// req       in         req_valid/req_ready; req_mode, req_load_index, req_load_value
// rsp       out        rsp_valid/rsp_ready; rsp_year .. rsp_second, rsp_selected_field,
//                      rsp_blink_on
// csr       in/out     APB: csr_psel, csr_penable, csr_pwrite, csr_paddr, csr_pwdata,
//                      csr_prdata, csr_pready
//
// One word per cycle sustained while rsp_ready is held high; a word passes the input
// register, then the update logic into the state and result registers, where
// rsp_valid rises.
// Reset is synchronous; it restores the calendar to year 0, January 1, 00:00:00.
// A stalled rsp holds the result register and the input register; req_ready drops
// only when both are full.
`default_nettype none

module calendar_time_set_editor_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [2:0]                         req_mode,
   input  wire logic [2:0]                         req_load_index,
   input  wire logic [6:0]                         req_load_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [6:0]                         rsp_year,
   output logic      [3:0]                         rsp_month,
   output logic      [4:0]                         rsp_day,
   output logic      [4:0]                         rsp_hour,
   output logic      [5:0]                         rsp_minute,
   output logic      [5:0]                         rsp_second,
   output logic      [2:0]                         rsp_selected_field,
   output logic                                    rsp_blink_on,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [cal_edit_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic      [31:0]                        csr_prdata,
   output logic                                    csr_pready
);

   logic [15:0]                 blink_period;
   cal_edit_pkg::cal_req_type   req_ff;
   logic                        req_valid_ff;
   cal_edit_pkg::cal_state_type state_ff;
   cal_edit_pkg::cal_state_type state_in;
   cal_edit_pkg::cal_state_type rsp_ff;
   logic                        rsp_valid_ff;
   logic                        advance;
   logic                        take;

   cal_edit_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .blink_period (blink_period)
   );

   cal_edit_update u_update (
      .cur          (state_ff),
      .req          (req_ff),
      .blink_period (blink_period),
      .nxt          (state_in)
   );

   // advance the held word when the result register is free or being drained
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= cal_edit_pkg::STATE_RST;
      end else begin
         if (take) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff.mode       <= req_mode;
         req_ff.load_index <= req_load_index;
         req_ff.load_value <= req_load_value;
      end
      if (advance) begin
         rsp_ff <= state_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_year           = rsp_ff.year;
   assign rsp_month          = rsp_ff.month;
   assign rsp_day            = rsp_ff.day;
   assign rsp_hour           = rsp_ff.hour;
   assign rsp_minute         = rsp_ff.minute;
   assign rsp_second         = rsp_ff.second;
   assign rsp_selected_field = rsp_ff.sel;
   assign rsp_blink_on       = rsp_ff.blink;

endmodule

`default_nettype wire

// File: tb/sv/calendar_checker.sv
module calendar_checker
   import cal_edit_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [2:0]            req_mode,
   input  wire logic [2:0]            req_load_index,
   input  wire logic [6:0]            req_load_value,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [6:0]            rsp_year,
   input  wire logic [3:0]            rsp_month,
   input  wire logic [4:0]            rsp_day,
   input  wire logic [4:0]            rsp_hour,
   input  wire logic [5:0]            rsp_minute,
   input  wire logic [5:0]            rsp_second,
   input  wire logic [2:0]            rsp_selected_field,
   input  wire logic                  rsp_blink_on,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   input  wire logic [31:0]           csr_prdata,
   input  wire logic                  csr_pready,
   output int unsigned                mismatch_count,
   output int unsigned                words_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_W-1:0] BLINK_PERIOD_ADDR = CSR_ADDR_W'(4 * CSR_BLINK_PERIOD);

   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [2:0] sel;
      logic       blink;
   } shown_calendar_type;

   cal_state_type      cal;
   logic [15:0]        blink_period;
   shown_calendar_type shown_q[$];

   initial begin
      mismatch_count  = 0;
      words_in_flight = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   function automatic logic [4:0] days_in(input logic [3:0] m, input logic [6:0] y);
      if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11)
         return 5'd30;
      if (m == 4'd2)
         return (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      return 5'd31;
   endfunction

   function automatic logic [6:0] clamp(input logic [6:0] v, input logic [6:0] lo,
                                         input logic [6:0] hi);
      if (v < lo)
         return lo;
      if (v > hi)
         return hi;
      return v;
   endfunction

   task automatic step_selected(input bit up);
      logic [4:0] len;
      len = days_in(cal.month, cal.year);
      case (cal.sel)
         FLD_YEAR: begin
            if (up)
               cal.year = (cal.year >= YEAR_MAX) ? 7'd0 : cal.year + 7'd1;
            else if (cal.year != 7'd0)
               cal.year = cal.year - 7'd1;
         end
         FLD_MONTH: begin
            if (up)
               cal.month = (cal.month >= MONTH_MAX) ? 4'd1 : cal.month + 4'd1;
            else
               cal.month = (cal.month <= 4'd1) ? MONTH_MAX : cal.month - 4'd1;
         end
         FLD_DAY: begin
            // a day past 31 wraps to zero here and is repaired below
            if (up)
               cal.day = cal.day + 5'd1;
            else
               cal.day = (cal.day <= 5'd1) ? len : cal.day - 5'd1;
         end
         FLD_HOUR: begin
            if (up)
               cal.hour = (cal.hour >= HOUR_MAX) ? 5'd0 : cal.hour + 5'd1;
            else
               cal.hour = (cal.hour == 5'd0) ? HOUR_MAX : cal.hour - 5'd1;
         end
         FLD_MINUTE: begin
            if (up)
               cal.minute = (cal.minute >= MINSEC_MAX) ? 6'd0 : cal.minute + 6'd1;
            else
               cal.minute = (cal.minute == 6'd0) ? MINSEC_MAX : cal.minute - 6'd1;
         end
         default: begin
            if (up)
               cal.second = (cal.second >= MINSEC_MAX) ? 6'd0 : cal.second + 6'd1;
            else
               cal.second = (cal.second == 6'd0) ? MINSEC_MAX : cal.second - 6'd1;
         end
      endcase
   endtask

   task automatic load_selected(input logic [2:0] idx, input logic [6:0] v);
      case (idx)
         FLD_YEAR:   cal.year   = clamp(v, 7'd0, YEAR_MAX);
         FLD_MONTH:  cal.month  = 4'(clamp(v, 7'd1, 7'(MONTH_MAX)));
         FLD_DAY:    cal.day    = 5'(clamp(v, 7'd1, 7'(days_in(cal.month, cal.year))));
         FLD_HOUR:   cal.hour   = 5'(clamp(v, 7'd0, 7'(HOUR_MAX)));
         FLD_MINUTE: cal.minute = 6'(clamp(v, 7'd0, 7'(MINSEC_MAX)));
         FLD_SECOND: cal.second = 6'(clamp(v, 7'd0, 7'(MINSEC_MAX)));
         default: ;
      endcase
   endtask

   task automatic repair_day();
      if (cal.day > days_in(cal.month, cal.year) || cal.day == 5'd0)
         cal.day = 5'd1;
   endtask

   task automatic apply_event(input cal_req_type ev);
      case (ev.mode)
         MODE_TICK: begin
            cal.tick = cal.tick + 16'd1;
            if (cal.tick >= blink_period) begin
               cal.tick  = 16'd0;
               cal.blink = ~cal.blink;
            end
         end
         MODE_NEXT: cal.sel = (cal.sel >= FLD_SECOND) ? FLD_YEAR : cal.sel + 3'd1;
         MODE_INC, MODE_DEC: begin
            step_selected(ev.mode == MODE_INC);
            repair_day();
         end
         MODE_LOAD: begin
            load_selected(ev.load_index, ev.load_value);
            repair_day();
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      shown_calendar_type want;
      cal_req_type        ev;
      if (reset) begin
         cal          = '0;
         cal.month    = 4'd1;
         cal.day      = 5'd1;
         blink_period = BLINK_PERIOD_RST;
         shown_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == BLINK_PERIOD_ADDR) begin
            if (csr_pwrite)
               blink_period = csr_pwdata[15:0];
            else
               check_field("blink_period readback", csr_prdata[15:0], blink_period);
         end
         if (rsp_valid && rsp_ready) begin
            if (shown_q.size() == 0) begin
               report_mismatch("result word with no event waiting");
            end else begin
               want = shown_q.pop_front();
               check_field("year", rsp_year, want.year);
               check_field("month", rsp_month, want.month);
               check_field("day", rsp_day, want.day);
               check_field("hour", rsp_hour, want.hour);
               check_field("minute", rsp_minute, want.minute);
               check_field("second", rsp_second, want.second);
               check_field("selected_field", rsp_selected_field, want.sel);
               check_field("blink_on", rsp_blink_on, want.blink);
            end
         end
         if (req_valid && req_ready) begin
            ev = '{mode: req_mode, load_index: req_load_index, load_value: req_load_value};
            apply_event(ev);
            want = '{year: cal.year, month: cal.month, day: cal.day, hour: cal.hour,
                     minute: cal.minute, second: cal.second, sel: cal.sel,
                     blink: cal.blink};
            shown_q.push_back(want);
         end
      end
      words_in_flight = shown_q.size();
   end

endmodule

// File: tb/sv/testbench.sv
module testbench
   import cal_edit_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_W-1:0] BLINK_PERIOD_ADDR = CSR_ADDR_W'(4 * CSR_BLINK_PERIOD);
   localparam int PHASES       = 6;
   localparam int PHASE_WORDS  = 275;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TIME  = 6;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic [2:0]            req_mode       = MODE_TICK;
   logic [2:0]            req_load_index = FLD_YEAR;
   logic [6:0]            req_load_value = 7'd0;
   logic                  rsp_ready      = 1'b0;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [31:0]           csr_pwdata     = 32'd0;

   logic        req_ready, rsp_valid, rsp_blink_on, csr_pready;
   logic [6:0]  rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day, rsp_hour;
   logic [5:0]  rsp_minute, rsp_second;
   logic [2:0]  rsp_selected_field;
   logic [31:0] csr_prdata;

   int unsigned mismatch_count, words_in_flight;
   int unsigned cycles = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;

   calendar_time_set_editor_top dut (.*);
   calendar_checker checker_inst (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic cal_req_type make_event(input logic [2:0] mode, input logic [2:0] idx,
                                              input logic [6:0] value);
      cal_req_type ev;
      ev.mode       = mode;
      ev.load_index = idx;
      ev.load_value = value;
      return ev;
   endfunction

   function automatic cal_req_type random_event();
      cal_req_type ev;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 30)
         ev.mode = MODE_TICK;
      else if (pick < 44)
         ev.mode = MODE_NEXT;
      else if (pick < 64)
         ev.mode = MODE_INC;
      else if (pick < 84)
         ev.mode = MODE_DEC;
      else if (pick < 97)
         ev.mode = MODE_LOAD;
      else
         ev.mode = 3'($urandom_range(7, int'(MODE_LOAD) + 1));
      if ($urandom_range(9) < 9)
         ev.load_index = 3'($urandom_range(int'(FLD_SECOND)));
      else
         ev.load_index = 3'($urandom_range(7, int'(FLD_SECOND) + 1));
      if ($urandom_range(1) == 0)
         ev.load_value = 7'($urandom);
      else
         ev.load_value = 7'($urandom_range(int'(YEAR_MAX)));
      return ev;
   endfunction

   // enter and leave at a falling edge; hold valid across back-to-back words
   task automatic send_event(input cal_req_type ev);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= ev.mode;
      req_load_index <= ev.load_index;
      req_load_value <= ev.load_value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // hold off the sender until every result word is back
   task automatic drain();
      req_valid <= 1'b0;
      while (words_in_flight != 0)
         @(negedge clock);
      repeat (SETTLE_TIME) @(negedge clock);
   endtask

   // write the period, then read it back in the following transfer
   task automatic program_blink_period(input logic [15:0] period);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= BLINK_PERIOD_ADDR;
      csr_pwdata  <= {16'd0, period};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      logic [15:0] periods[PHASES];
      periods = '{16'd1, 16'hFFFF, 16'd0, 16'd3, BLINK_PERIOD_RST,
                  16'($urandom_range(40, 2))};
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // year wrap and clamp at zero
      send_event(make_event(MODE_LOAD, FLD_YEAR, 7'd99));
      send_event(make_event(MODE_INC, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_DEC, FLD_YEAR, 7'd0));
      // saturating loads from the all-ones value
      send_event(make_event(MODE_LOAD, FLD_MONTH, 7'h7F));
      send_event(make_event(MODE_LOAD, FLD_DAY, 7'h7F));
      send_event(make_event(MODE_NEXT, FLD_YEAR, 7'd0));
      // December to January, then into a leap February, which drops day 31 to 1
      send_event(make_event(MODE_INC, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_INC, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_LOAD, FLD_DAY, 7'd30));
      // non-leap year drops day 29 back to 1
      send_event(make_event(MODE_LOAD, FLD_YEAR, 7'd1));
      send_event(make_event(MODE_LOAD, FLD_DAY, 7'd0));
      send_event(make_event(MODE_DEC, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_DEC, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_NEXT, FLD_YEAR, 7'd0));
      // day below 1 and past month end
      send_event(make_event(MODE_DEC, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_INC, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_NEXT, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_DEC, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_INC, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_LOAD, FLD_HOUR, 7'h7F));
      send_event(make_event(MODE_LOAD, FLD_MINUTE, 7'h7F));
      send_event(make_event(MODE_LOAD, FLD_SECOND, 7'h7F));
      send_event(make_event(MODE_NEXT, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_INC, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_NEXT, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_INC, FLD_YEAR, 7'd0));
      send_event(make_event(MODE_NEXT, FLD_YEAR, 7'd0));
      // loads to a missing field and modes without meaning
      send_event(make_event(MODE_LOAD, 3'd7, 7'd5));
      send_event(make_event(3'd7, 3'd6, 7'h7F));
      send_event(make_event(MODE_TICK, FLD_YEAR, 7'd0));
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         program_blink_period(periods[phase]);
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 69;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 69;
            end
            default: begin
               send_idle_pct = 34;
               rsp_stall_pct = 34;
            end
         endcase
         repeat (PHASE_WORDS) send_event(random_event());
         drain();
      end

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
